### design/nscs_pkg.sv
// Shared types, constants and helper functions for the NAL start code scanner.
`timescale 1ns / 1ps

package nscs_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int FIELD_W     = 24;
    localparam int SZ_W        = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 2;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [1:0] ST_UNIT      = 2'd0;
    localparam logic [1:0] ST_NO_HEADER = 2'd1;
    localparam logic [1:0] ST_SHORT     = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    localparam logic [2:0] PFX_SHORT = 3'd3;
    localparam logic [2:0] PFX_LONG  = 3'd4;

    localparam logic [7:0] START_BYTE = 8'h01;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] unit_start;
        logic [2:0]         prefix_size;
        logic [1:0]         ref_idc;
        logic [4:0]         unit_type;
        logic               forbidden_bit_set;
        logic [FIELD_W-1:0] unit_size;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0] push_cnt;
        result_t    first;
        result_t    second;
    } scan_push_t;

    function automatic logic [SZ_W-1:0] widen(input logic [OFFSET_BITS-1:0] v);
        widen = SZ_W'(v);
    endfunction

    function automatic logic [FIELD_W-1:0] sat_size(input logic [SZ_W-1:0] d);
        sat_size = d[SZ_W-1] ? '0 : d[FIELD_W-1:0];
    endfunction

    function automatic result_t make_result(
        input logic [1:0]             status,
        input logic [OFFSET_BITS-1:0] start,
        input logic [2:0]             pfx,
        input logic [7:0]             hdr,
        input logic [FIELD_W-1:0]     size,
        input logic                   last
    );
        result_t r;
        r.status            = status;
        r.unit_start        = FIELD_W'(start);
        r.prefix_size       = pfx;
        r.ref_idc           = hdr[6:5];
        r.unit_type         = hdr[4:0];
        r.forbidden_bit_set = hdr[7];
        r.unit_size         = size;
        r.last              = last;
        make_result = r;
    endfunction

endpackage

### design/nscs_scanner.sv
// Per-byte start code detection, unit tracking and result formation.
`timescale 1ns / 1ps

module nscs_scanner
    import nscs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       end_of_packet,
    output scan_push_t push
);

    logic [OFFSET_BITS-1:0] pos_reg;
    logic [2:0]             zero_flags_reg;
    logic                   awaiting_reg;
    logic                   unit_open_reg;
    logic [OFFSET_BITS-1:0] open_start_reg;
    logic [2:0]             open_pfx_reg;
    logic [7:0]             open_hdr_reg;

    logic                   start_code;
    logic [7:0]             hdr_eff;
    logic [OFFSET_BITS-1:0] start3;
    logic [OFFSET_BITS-1:0] start;
    logic [2:0]             pfx;
    logic [FIELD_W-1:0]     close_size;
    logic                   unit_open_next;
    logic [OFFSET_BITS-1:0] open_start_next;
    logic [2:0]             open_pfx_next;
    logic [7:0]             open_hdr_next;
    logic [FIELD_W-1:0]     eop_size;
    result_t                close_res;
    result_t                eop_res;

    always_comb begin
        hdr_eff    = awaiting_reg ? data_byte : open_hdr_reg;
        start_code = (data_byte == START_BYTE) && (zero_flags_reg[1:0] == 2'b11);
        start3     = pos_reg - OFFSET_BITS'(2);
        start      = zero_flags_reg[2] ? (start3 - OFFSET_BITS'(1)) : start3;
        pfx        = zero_flags_reg[2] ? PFX_LONG : PFX_SHORT;
        close_size = sat_size(widen(start) - widen(open_start_reg) - SZ_W'(open_pfx_reg));
        close_res  = make_result(ST_UNIT, open_start_reg, open_pfx_reg, hdr_eff,
                                 close_size, 1'b0);

        unit_open_next  = unit_open_reg | start_code;
        open_start_next = start_code ? start : open_start_reg;
        open_pfx_next   = start_code ? pfx : open_pfx_reg;
        open_hdr_next   = start_code ? 8'h00 : hdr_eff;

        eop_size = sat_size(widen(pos_reg) - widen(open_start_next) - SZ_W'(open_pfx_next));
        if (unit_open_next) begin
            if (start_code) begin
                eop_res = make_result(ST_NO_HEADER, open_start_next, open_pfx_next, 8'h00,
                                      eop_size, 1'b1);
            end else begin
                eop_res = make_result(ST_UNIT, open_start_next, open_pfx_next,
                                      open_hdr_next, eop_size, 1'b1);
            end
        end else if (pos_reg < OFFSET_BITS'(2)) begin
            eop_res = make_result(ST_SHORT, '0, 3'd0, 8'h00, '0, 1'b1);
        end else begin
            eop_res = make_result(ST_NONE, '0, 3'd0, 8'h00, '0, 1'b1);
        end

        push.second = eop_res;
        if (start_code && unit_open_reg) begin
            push.first    = close_res;
            push.push_cnt = end_of_packet ? 2'd2 : 2'd1;
        end else begin
            push.first    = eop_res;
            push.push_cnt = end_of_packet ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            zero_flags_reg <= '0;
            awaiting_reg   <= 1'b0;
            unit_open_reg  <= 1'b0;
            open_start_reg <= '0;
            open_pfx_reg   <= PFX_SHORT;
            open_hdr_reg   <= '0;
        end else if (in_fire) begin
            if (end_of_packet) begin
                pos_reg        <= '0;
                zero_flags_reg <= '0;
                awaiting_reg   <= 1'b0;
                unit_open_reg  <= 1'b0;
                open_start_reg <= '0;
                open_pfx_reg   <= PFX_SHORT;
                open_hdr_reg   <= '0;
            end else begin
                pos_reg        <= pos_reg + OFFSET_BITS'(1);
                zero_flags_reg <= {zero_flags_reg[1:0], (data_byte == 8'h00)};
                awaiting_reg   <= start_code;
                unit_open_reg  <= unit_open_next;
                open_start_reg <= open_start_next;
                open_pfx_reg   <= open_pfx_next;
                open_hdr_reg   <= open_hdr_next;
            end
        end
    end

endmodule

### design/nal_start_code_scanner.sv
// Top level of the NAL start code scanner: byte input, scanner and result queue.
// Usage:
// Packet bytes arrive on the s_ channel one request per byte, with s_tlast on the
// final byte of a packet. Each unit found is reported on the m_ channel when the
// next start code closes it or when the packet ends; m_tuser carries the status.
// Every packet produces at least one result, and its final result has m_tlast set.
// A byte is accepted every clock cycle while the four-entry result queue has room
// for two results, so the sustained rate is one byte per cycle; that figure is set
// by the single registered scan step per byte.
// A result is written into the registered result queue by the byte that causes it and
// is shown on the m_ side once earlier results are taken. An end of packet byte that
// closes a unit and opens a headerless one yields two results, queued together.
// When the receiver stalls, results stay queued and s_tready drops once fewer than
// two queue entries are free, so no result is lost.
// A synchronous low aresetn empties the queue and clears all packet state; the
// next byte accepted is taken as the first byte of a new packet.
`timescale 1ns / 1ps

module nal_start_code_scanner
    import nscs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // unit_start, prefix_size, ref_idc, unit_type,
                                   // forbidden_bit_set, unit_size, zero fill
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast    // last
);

    scan_push_t        push;
    logic              s_fire;
    logic              m_fire;
    logic [1:0]        push_n;
    result_t           oq_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]  wr_ptr_reg;
    logic [OQ_AW-1:0]  rd_ptr_reg;
    logic [OQ_AW:0]    count_reg;
    logic [OQ_AW:0]    count_next;
    result_t           head;

    assign s_tready = (count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_fire   = m_tvalid && m_tready;
    assign push_n   = s_fire ? push.push_cnt : 2'd0;

    nscs_scanner u_scanner (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (s_fire),
        .data_byte     (s_tdata),
        .end_of_packet (s_tlast),
        .push          (push)
    );

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            oq_mem[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2) begin
            oq_mem[wr_ptr_reg + OQ_AW'(1)] <= push.second;
        end
    end

    assign count_next = count_reg + (OQ_AW+1)'(push_n) - (OQ_AW+1)'(m_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OQ_AW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + OQ_AW'(m_fire);
            count_reg  <= count_next;
        end
    end

    assign head    = oq_mem[rd_ptr_reg];
    assign m_tdata = {5'b0, head.unit_size, head.forbidden_bit_set, head.unit_type,
                      head.ref_idc, head.prefix_size, head.unit_start};
    assign m_tuser = head.status;
    assign m_tlast = head.last;

    // The queue never holds more results than it has entries.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue overflow");

    // Two results from one byte happen only on the final byte of a packet.
    a_double_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (push.push_cnt == 2'd2) |-> s_tlast)
        else $error("two results from a byte that does not end the packet");

    // The end of a packet always leaves a result waiting in the next cycle.
    a_eop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> m_tvalid)
        else $error("packet ended without a result");

endmodule
